@@ sv/htfd_pkg.sv @@
package htfd_pkg;

  // Error codes reported with every result.
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_NOACK = 3'd1;
  localparam logic [2:0] ERR_BUSY  = 3'd2;
  localparam logic [2:0] ERR_NOCAL = 3'd3;
  localparam logic [2:0] ERR_RANGE = 3'd4;

  // Status bit positions.
  localparam int unsigned STATUS_BUSY_BIT = 7;
  localparam int unsigned STATUS_CAL_BIT  = 3;

  // Accepted raw temperature window, -40 C to 85 C.
  localparam logic [19:0] RAW_T_MIN = 20'd52429;
  localparam logic [19:0] RAW_T_MAX = 20'd707788;

  // Fixed-point scale factors; products are shifted right by 20.
  localparam logic [13:0] HUM_SCALE  = 14'd10000;
  localparam logic [14:0] TEMP_SCALE = 15'd20000;
  localparam logic signed [14:0] TEMP_OFFSET = 15'sd5000;

  // Reset value of the failure limit register.
  localparam logic [7:0] FAIL_LIMIT_RESET = 8'd10;

  // One classified frame as it travels from the front end to the back end.
  typedef struct packed {
    logic [2:0]         err;
    logic [13:0]        hum;
    logic signed [14:0] temp;
  } htfd_item_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } htfd_qstat_t;

endpackage

@@ sv/htfd_front.sv @@
module htfd_front (
  input  logic              addr_acked,
  input  logic [7:0]        status_byte,
  input  logic [7:0]        data_byte1,
  input  logic [7:0]        data_byte2,
  input  logic [7:0]        data_byte3,
  input  logic [7:0]        data_byte4,
  input  logic [7:0]        data_byte5,
  output htfd_pkg::htfd_item_t item
);
  import htfd_pkg::*;

  logic [19:0] raw_h;
  logic [19:0] raw_t;
  logic [33:0] hum_prod;
  logic [34:0] temp_prod;
  logic [14:0] temp_scaled;
  logic [2:0]  err;

  // Unpack the two 20-bit raw readings.
  assign raw_h = {data_byte1, data_byte2, data_byte3[7:4]};
  assign raw_t = {data_byte3[3:0], data_byte4, data_byte5};

  // Scale to hundredths; the upper product bits are the truncated result.
  assign hum_prod    = {14'd0, raw_h} * {20'd0, HUM_SCALE};
  assign temp_prod   = {15'd0, raw_t} * {20'd0, TEMP_SCALE};
  assign temp_scaled = temp_prod[34:20];

  assign item.hum  = hum_prod[33:20];
  assign item.temp = $signed(temp_scaled) - TEMP_OFFSET;
  assign item.err  = err;

  // Classify the frame; earlier checks take priority.
  always_comb begin
    if (!addr_acked) begin
      err = ERR_NOACK;
    end else if (status_byte[STATUS_BUSY_BIT]) begin
      err = ERR_BUSY;
    end else if (!status_byte[STATUS_CAL_BIT]) begin
      err = ERR_NOCAL;
    end else if (raw_t < RAW_T_MIN || raw_t > RAW_T_MAX) begin
      err = ERR_RANGE;
    end else begin
      err = ERR_NONE;
    end
  end

endmodule

@@ sv/htfd_queue.sv @@
module htfd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  htfd_pkg::htfd_item_t push_item,
  input  logic                 pop,
  output htfd_pkg::htfd_item_t head_item,
  output htfd_pkg::htfd_qstat_t stat
);
  import htfd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  htfd_item_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == CNT_FULL);
  assign stat.empty = (count == '0);
  assign head_item  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/htfd_back.sv @@
module htfd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  htfd_pkg::htfd_item_t  head_item,
  input  htfd_pkg::htfd_qstat_t stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  ok,
  output logic [2:0]            error_code,
  output logic [13:0]           humidity_centi,
  output logic signed [14:0]    temp_centi,
  output logic [7:0]            fail_count
);
  import htfd_pkg::*;

  logic [7:0]         fail_limit;
  logic [7:0]         fail_counter;
  logic [7:0]         fail_counter_next;
  logic [13:0]        last_humidity;
  logic [13:0]        last_humidity_next;
  logic signed [14:0] last_temperature;
  logic signed [14:0] last_temperature_next;
  logic               good;

  // Take the next frame when the output register is empty or being drained.
  assign pop  = !stat.empty && (!out_valid || out_ready);
  assign good = (head_item.err == ERR_NONE);

  // Held values and the saturating failure counter after this frame.
  always_comb begin
    fail_counter_next     = fail_counter;
    last_humidity_next    = last_humidity;
    last_temperature_next = last_temperature;
    if (good) begin
      fail_counter_next     = '0;
      last_humidity_next    = head_item.hum;
      last_temperature_next = head_item.temp;
    end else if (fail_counter < fail_limit) begin
      fail_counter_next = fail_counter + 8'd1;
    end
  end

  // Limit register, state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      fail_limit       <= FAIL_LIMIT_RESET;
      fail_counter     <= '0;
      last_humidity    <= '0;
      last_temperature <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        fail_limit <= cfg_wdata;
      end
      if (pop) begin
        fail_counter     <= fail_counter_next;
        last_humidity    <= last_humidity_next;
        last_temperature <= last_temperature_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (pop) begin
      ok             <= good;
      error_code     <= head_item.err;
      humidity_centi <= last_humidity_next;
      temp_centi     <= last_temperature_next;
      fail_count     <= fail_counter_next;
    end
  end

endmodule

@@ sv/humidity_temperature_frame_decode.sv @@
// Path: a frame is written into the queue, then into the output register.
// Throughput: one frame per cycle while the queue has room; the front end
// classifies and scales in the accept cycle, and the queue (two entries by
// default) plus the output register keep the input open while a result waits.
// Reset (rst, synchronous): queue empty, no result valid, failure counter and
// held values zero, fail_limit back to 10.
module humidity_temperature_frame_decode #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               addr_acked,
  input  logic [7:0]         status_byte,
  input  logic [7:0]         data_byte1,
  input  logic [7:0]         data_byte2,
  input  logic [7:0]         data_byte3,
  input  logic [7:0]         data_byte4,
  input  logic [7:0]         data_byte5,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               ok,
  output logic [2:0]         error_code,
  output logic [13:0]        humidity_centi,
  output logic signed [14:0] temp_centi,
  output logic [7:0]         fail_count
);
  import htfd_pkg::*;

  htfd_item_t  front_item;
  htfd_item_t  head_item;
  htfd_qstat_t stat;
  logic        push;
  logic        pop;

  assign in_ready = !stat.full;
  assign push     = in_valid && in_ready;

  // Front end: classify and scale the frame.
  htfd_front u_front (
    .addr_acked  (addr_acked),
    .status_byte (status_byte),
    .data_byte1  (data_byte1),
    .data_byte2  (data_byte2),
    .data_byte3  (data_byte3),
    .data_byte4  (data_byte4),
    .data_byte5  (data_byte5),
    .item        (front_item)
  );

  // Queue between the front and back ends.
  htfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (stat)
  );

  // Back end: state update and result register.
  htfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .head_item      (head_item),
    .stat           (stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .error_code     (error_code),
    .humidity_centi (humidity_centi),
    .temp_centi     (temp_centi),
    .fail_count     (fail_count)
  );

  // A good result always clears the failure counter.
  a_ok_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && ok |-> error_code == ERR_NONE && fail_count == 8'd0)
    else $error("good result with error code or nonzero fail count");

  // A failed result always carries an error code.
  a_fail_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> error_code != ERR_NONE)
    else $error("failed result without error code");

  // The queue cannot be full and empty at once.
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(stat.full && stat.empty))
    else $error("queue full and empty together");

  // Nothing is taken from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

endmodule

@@ test/humidity_temperature_frame_decode_test.sv @@
module humidity_temperature_frame_decode_test;
  timeunit 1ns;
  timeprecision 1ps;

  import htfd_pkg::*;

  // Raw temperature window for -40 C to 85 C, worked out from the scale.
  localparam logic [19:0] TEMP_RAW_LO = 20'd52429;
  localparam logic [19:0] TEMP_RAW_HI = 20'd707788;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 430;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic       ack;
    logic [7:0] status;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
  } frame_t;

  typedef struct packed {
    logic               ok;
    logic [2:0]         err;
    logic [13:0]        hum;
    logic signed [14:0] temp;
    logic [7:0]         cnt;
  } decode_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [7:0]         cfg_wdata = 8'd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               addr_acked = 1'b0;
  logic [7:0]         status_byte = 8'd0;
  logic [7:0]         data_byte1 = 8'd0;
  logic [7:0]         data_byte2 = 8'd0;
  logic [7:0]         data_byte3 = 8'd0;
  logic [7:0]         data_byte4 = 8'd0;
  logic [7:0]         data_byte5 = 8'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               ok;
  logic [2:0]         error_code;
  logic [13:0]        humidity_centi;
  logic signed [14:0] temp_centi;
  logic [7:0]         fail_count;

  // Frames waiting to be sent and decoded results waiting to arrive.
  frame_t         pending_frames[$];
  decode_result_t expected_results[$];
  frame_t         frame_on_bus;

  // Shadow copy of the decoder state and its limit register.
  logic [7:0]         limit_shadow = 8'd10;
  logic [7:0]         fail_shadow = 8'd0;
  logic [13:0]        hum_shadow = 14'd0;
  logic signed [14:0] temp_shadow = 15'sd0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int frames_queued = 0;
  int frames_accepted = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int good_frames = 0;
  int bad_frames = 0;
  int held_at_limit = 0;
  int limit_settings = 0;
  int cycle_count = 0;

  humidity_temperature_frame_decode dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .addr_acked     (addr_acked),
    .status_byte    (status_byte),
    .data_byte1     (data_byte1),
    .data_byte2     (data_byte2),
    .data_byte3     (data_byte3),
    .data_byte4     (data_byte4),
    .data_byte5     (data_byte5),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .error_code     (error_code),
    .humidity_centi (humidity_centi),
    .temp_centi     (temp_centi),
    .fail_count     (fail_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decode one frame against the shadow state and return what the block should report.
  function automatic decode_result_t decode_frame(input frame_t f);
    logic [19:0]    raw_h;
    logic [19:0]    raw_t;
    logic [63:0]    prod;
    logic [2:0]     err;
    decode_result_t r;
    raw_h = {f.b1, f.b2, f.b3[7:4]};
    raw_t = {f.b3[3:0], f.b4, f.b5};
    if (!f.ack) begin
      err = ERR_NOACK;
    end else if (f.status[STATUS_BUSY_BIT]) begin
      err = ERR_BUSY;
    end else if (!f.status[STATUS_CAL_BIT]) begin
      err = ERR_NOCAL;
    end else if (raw_t < TEMP_RAW_LO || raw_t > TEMP_RAW_HI) begin
      err = ERR_RANGE;
    end else begin
      err = ERR_NONE;
    end
    if (err == ERR_NONE) begin
      prod = ({44'd0, raw_h} * 64'd10000) >> 20;
      hum_shadow = prod[13:0];
      prod = ({44'd0, raw_t} * 64'd20000) >> 20;
      temp_shadow = $signed(prod[14:0]) - 15'sd5000;
      fail_shadow = 8'd0;
      good_frames++;
    end else begin
      // The counter only climbs while it is below the limit.
      if (fail_shadow < limit_shadow) begin
        fail_shadow = fail_shadow + 8'd1;
      end else begin
        held_at_limit++;
      end
      bad_frames++;
    end
    r.ok = (err == ERR_NONE);
    r.err = err;
    r.hum = hum_shadow;
    r.temp = temp_shadow;
    r.cnt = fail_shadow;
    return r;
  endfunction

  function automatic frame_t build_frame(input logic ack, input logic [7:0] status,
                                         input logic [19:0] raw_h, input logic [19:0] raw_t);
    frame_t f;
    f.ack = ack;
    f.status = status;
    f.b1 = raw_h[19:12];
    f.b2 = raw_h[11:4];
    f.b3 = {raw_h[3:0], raw_t[19:16]};
    f.b4 = raw_t[15:8];
    f.b5 = raw_t[7:0];
    return f;
  endfunction

  // A calibrated, idle status byte with a random in-range temperature.
  function automatic frame_t good_frame();
    logic [7:0]  status;
    logic [19:0] raw_h;
    logic [19:0] raw_t;
    status = 8'(($urandom & 8'h7F) | 8'h08);
    raw_h = 20'($urandom);
    if ($urandom_range(9) == 0) begin
      raw_t = 20'($urandom_range(1) ? TEMP_RAW_LO + $urandom_range(3)
                                    : TEMP_RAW_HI - $urandom_range(3));
    end else begin
      raw_t = 20'($urandom_range(TEMP_RAW_HI, TEMP_RAW_LO));
    end
    return build_frame(1'b1, status, raw_h, raw_t);
  endfunction

  // A frame that fails one of the four checks, chosen at random.
  function automatic frame_t failing_frame();
    frame_t      f;
    logic [19:0] raw_t;
    f = good_frame();
    case ($urandom_range(3))
      0: begin
        f.ack = 1'b0;
        f.status = 8'($urandom);
      end
      1: begin
        f.status = 8'(f.status | 8'h80 | ($urandom & 8'h08));
      end
      2: begin
        f.status = f.status & 8'h77;
      end
      default: begin
        raw_t = 20'($urandom_range(1) ? $urandom_range(TEMP_RAW_LO - 1, 0)
                                      : $urandom_range(20'hFFFFF, TEMP_RAW_HI + 1));
        f = build_frame(1'b1, f.status, {f.b1, f.b2, f.b3[7:4]}, raw_t);
      end
    endcase
    return f;
  endfunction

  function automatic frame_t noise_frame();
    return build_frame(1'($urandom_range(1)), 8'($urandom), 20'($urandom), 20'($urandom));
  endfunction

  task automatic queue_frame(input frame_t f);
    pending_frames.push_back(f);
    frames_queued++;
  endtask

  // Returns once every queued frame has produced its checked result.
  task automatic wait_drain();
    do @(posedge clk); while (results_checked != frames_queued);
  endtask

  task automatic write_limit(input logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    limit_shadow = value;
    limit_settings++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Input driver: predict on each accepted transaction, then offer the next frame.
  always @(posedge clk) begin : drive_frames
    frame_t f;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(decode_frame(frame_on_bus));
        frames_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          f = pending_frames.pop_front();
          frame_on_bus = f;
          in_valid <= 1'b1;
          addr_acked <= f.ack;
          status_byte <= f.status;
          data_byte1 <= f.b1;
          data_byte2 <= f.b2;
          data_byte3 <= f.b3;
          data_byte4 <= f.b4;
          data_byte5 <= f.b5;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    decode_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: result with no frame outstanding: ok=%0b err=%0d", $realtime,
                     ok, error_code);
          end
        end else begin
          want = expected_results.pop_front();
          if (ok !== want.ok || error_code !== want.err || humidity_centi !== want.hum ||
              temp_centi !== want.temp || fail_count !== want.cnt) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("%0t: mismatch on result %0d", $realtime, results_checked);
              $display("  expected ok=%0b err=%0d hum=%0d temp=%0d count=%0d",
                       want.ok, want.err, want.hum, want.temp, want.cnt);
              $display("  actual   ok=%0b err=%0d hum=%0d temp=%0d count=%0d",
                       ok, error_code, humidity_centi, temp_centi, fail_count);
            end
          end
          results_checked++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the total number of cycles.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int burst_left;
    int pick;
    frame_t f;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset limit: window edges, scale extremes,
    // and each rejection in order of priority.
    queue_frame(build_frame(1'b1, 8'h08, 20'd0, TEMP_RAW_LO));
    queue_frame(build_frame(1'b1, 8'h08, 20'hFFFFF, TEMP_RAW_HI));
    queue_frame(build_frame(1'b1, 8'h7F, 20'($urandom), TEMP_RAW_LO - 20'd1));
    queue_frame(build_frame(1'b1, 8'h18, 20'($urandom), TEMP_RAW_HI + 20'd1));
    queue_frame(build_frame(1'b1, 8'h08, 20'($urandom), 20'd0));
    queue_frame(build_frame(1'b1, 8'h08, 20'($urandom), 20'hFFFFF));
    queue_frame(build_frame(1'b0, 8'hFF, 20'hFFFFF, 20'hFFFFF));
    queue_frame(build_frame(1'b0, 8'h08, 20'($urandom), 20'd400000));
    queue_frame(build_frame(1'b1, 8'hFF, 20'($urandom), 20'd400000));
    queue_frame(build_frame(1'b1, 8'h80, 20'($urandom), 20'd400000));
    queue_frame(build_frame(1'b1, 8'h77, 20'($urandom), 20'd400000));
    queue_frame(build_frame(1'b1, 8'h00, 20'd0, 20'd0));
    queue_frame(build_frame(1'b1, 8'h08, 20'h80000, 20'd400000));
    wait_drain();

    // A small limit saturates quickly; a good frame then clears the counter.
    write_limit(8'd2);
    repeat (4) queue_frame(failing_frame());
    queue_frame(good_frame());
    wait_drain();

    // With a zero limit failures never count.
    write_limit(8'd0);
    repeat (2) queue_frame(failing_frame());
    wait_drain();

    // Lowering the limit below the count leaves the count where it is.
    write_limit(8'd3);
    repeat (3) queue_frame(failing_frame());
    wait_drain();
    write_limit(8'd1);
    queue_frame(failing_frame());
    queue_frame(good_frame());
    wait_drain();

    // Random phases, each with its own idle profile and limit.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_limit(8'd255);
        end
        1: begin
          send_idle_pct = 45;
          recv_stall_pct = 0;
          write_limit(8'($urandom_range(15, 1)));
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 45;
          write_limit(8'($urandom_range(255)));
        end
        default: begin
          send_idle_pct = 20;
          recv_stall_pct = 20;
          write_limit(8'($urandom_range(20)));
        end
      endcase
      burst_left = 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Halfway through, hold off until the block has emptied.
        if (i == ITEMS_PER_PHASE / 2) begin
          wait_drain();
        end
        if (burst_left > 0) begin
          f = failing_frame();
          burst_left--;
        end else begin
          pick = $urandom_range(99);
          if (pick < 3) begin
            burst_left = $urandom_range(300, 5);
            f = failing_frame();
          end else if (pick < 68) begin
            f = good_frame();
          end else if (pick < 85) begin
            f = failing_frame();
          end else begin
            f = noise_frame();
          end
        end
        queue_frame(f);
      end
      wait_drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drain();
    repeat (5) @(posedge clk);

    $display("Summary: %0d frames checked across %0d limit settings and four idle profiles.",
             results_checked, limit_settings);
    $display("Summary: %0d decoded, %0d rejected, %0d failures held at the counter limit.",
             good_frames, bad_frames, held_at_limit);
    if (mismatch_count == 0 && expected_results.size() == 0 &&
        frames_accepted == frames_queued) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
